// ===== rtl/dtjc_pkg.sv =====
package dtjc_pkg;

  // fraction bits of the normalized depth t
  localparam int NORM_FRAC_BITS = 16;

  localparam int RAW_W   = 16;
  localparam int SCALE_W = 32;
  localparam int COORD_W = 32;
  localparam int DEPTH_W = RAW_W + SCALE_W;   // Q.24 depth product
  localparam int DIFF_W  = DEPTH_W + 2;       // signed depth - near
  localparam int CH_W    = 8;
  localparam int CFG_W   = 32;
  localparam int CFG_A_W = 2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd16777;
  localparam logic [COORD_W-1:0] NEAR_RST  = 32'd0;
  localparam logic [COORD_W-1:0] FAR_RST   = 32'd655360;
  localparam logic [CH_W-1:0]    ALPHA_VAL = 8'd255;

  typedef enum logic [CFG_A_W-1:0] {
    REG_DEPTH_SCALE = 2'd0,
    REG_NEAR_DEPTH  = 2'd1,
    REG_FAR_DEPTH   = 2'd2
  } cfg_reg_t;

  // per-pixel flags that ride along the pipeline
  typedef struct packed {
    logic err;    // bad setup
    logic blank;  // colors forced to zero
    logic sat;    // t clamped to one
  } side_t;

endpackage

// ===== rtl/dtjc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Divides {p, low, zeros} by rng; p < rng required. q has NormFracBits bits.
module dtjc_div #(
  parameter int NormFracBits = dtjc_pkg::NORM_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              in_p,
  input  logic [7:0]               in_low,
  input  logic [31:0]              in_rng,
  input  dtjc_pkg::side_t          in_side,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [NormFracBits-1:0]  out_q,
  output dtjc_pkg::side_t          out_side
);

  localparam int N = NormFracBits;

  logic [N-1:0]                vld_r;
  logic [N-1:0][31:0]          p_r;
  logic [N-1:0][N-1:0]         dlo_r;
  logic [N-1:0][N-1:0]         q_r;
  logic [N-1:0][31:0]          rng_r;
  dtjc_pkg::side_t [N-1:0]     side_r;
  logic [N-1:0]                rdy;

  logic [N+7:0] lo_ext;
  logic [N-1:0] dlo_init;

  // low N dividend bits: low byte on top, zeros below
  assign lo_ext   = {in_low, {N{1'b0}}};
  assign dlo_init = lo_ext[N+7:8];

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_stage
      logic                src_v;
      logic [31:0]         src_p;
      logic [N-1:0]        src_dlo;
      logic [N-1:0]        src_q;
      logic [31:0]         src_rng;
      dtjc_pkg::side_t     src_side;
      logic [32:0]         trial;
      logic                ge;
      logic [32:0]         rem;

      if (j == 0) begin : g_src_in
        assign src_v    = in_valid;
        assign src_p    = in_p;
        assign src_dlo  = dlo_init;
        assign src_q    = '0;
        assign src_rng  = in_rng;
        assign src_side = in_side;
      end else begin : g_src_prev
        assign src_v    = vld_r[j-1];
        assign src_p    = p_r[j-1];
        assign src_dlo  = dlo_r[j-1];
        assign src_q    = q_r[j-1];
        assign src_rng  = rng_r[j-1];
        assign src_side = side_r[j-1];
      end

      if (j == N-1) begin : g_rdy_last
        assign rdy[j] = !vld_r[j] || out_ready;
      end else begin : g_rdy_mid
        assign rdy[j] = !vld_r[j] || rdy[j+1];
      end

      assign trial = {src_p, src_dlo[N-1]};
      assign ge    = trial >= {1'b0, src_rng};
      assign rem   = ge ? (trial - {1'b0, src_rng}) : trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (rdy[j]) begin
          vld_r[j] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[j] && src_v) begin
          p_r[j]    <= rem[31:0];
          dlo_r[j]  <= {src_dlo[N-2:0], 1'b0};
          q_r[j]    <= {src_q[N-2:0], ge};
          rng_r[j]  <= src_rng;
          side_r[j] <= src_side;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[N-1];
  assign out_q     = q_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== rtl/depth_to_jet_color.sv =====
// depth_to_jet_color: jet colormap for a 16-bit depth pixel stream.
//
// in_*  : one raw depth sample per request (in_tdata[15:0]); zero = no data.
// out_* : one RGBA pixel per request, out_tdata = {alpha, blue, green, red},
//         out_tuser = setup error (scale zero or far <= near; colors are 0).
// cfg_* : plain register write: 0 depth_scale (Q8.24), 1 near_depth and
//         2 far_depth (signed Q16.16). Write only while the stream is idle.
//
// Throughput is one pixel per clock while out_tready is not stalling the
// pipeline. It has four front stages (capture, scale multiply, near
// subtract, range compare), one stage per quotient bit in the divider that
// forms t, then the triangle-wave stage and the output register.
// Each stage holds a valid bit and advances when the stage behind it is
// empty or moving, so bubbles close up and a stall on out_tready backs
// up stage by stage without loss or duplication.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// register defaults: scale 16777, near 0, far 10.0 m.
module depth_to_jet_color #(
  parameter int NormFracBits = dtjc_pkg::NORM_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // raw_depth
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dtjc_pkg::RAW_W-1:0]    in_tdata,
  // red, green, blue, alpha
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [4*dtjc_pkg::CH_W-1:0]   out_tdata,
  // setup_error
  output logic                          out_tuser,
  input  logic                          cfg_wr_en,
  input  logic [dtjc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [dtjc_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int N      = NormFracBits;
  localparam int DEPTHW = dtjc_pkg::DEPTH_W;
  localparam int DIFFW  = dtjc_pkg::DIFF_W;
  localparam int CHW    = dtjc_pkg::CH_W;

  localparam logic [N:0]          One    = (N+1)'(1) << N;
  localparam logic signed [N+3:0] OneHlf = (N+4)'(3) << (N-1);  // 1.5
  localparam logic [N+8:0]        Half   = (N+9)'(1) << (N-1);

  // ---------------- configuration registers ----------------
  logic [31:0] scale_r, near_r, far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= dtjc_pkg::SCALE_RST;
      near_r  <= dtjc_pkg::NEAR_RST;
      far_r   <= dtjc_pkg::FAR_RST;
    end else if (cfg_wr_en) begin
      unique case (dtjc_pkg::cfg_reg_t'(cfg_addr))
        dtjc_pkg::REG_DEPTH_SCALE: scale_r <= cfg_wdata;
        dtjc_pkg::REG_NEAR_DEPTH:  near_r  <= cfg_wdata;
        dtjc_pkg::REG_FAR_DEPTH:   far_r   <= cfg_wdata;
        default: ;  // index past the list: ignored
      endcase
    end
  end

  // ---------------- stall chain ----------------
  logic va_r, vb_r, vc_r, vd_r, vw_r, vo_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_w, rdy_o;
  logic div_in_ready, div_out_valid;

  assign rdy_o     = !vo_r || out_tready;
  assign rdy_w     = !vw_r || rdy_o;
  assign rdy_d     = !vd_r || div_in_ready;
  assign rdy_c     = !vc_r || rdy_d;
  assign rdy_b     = !vb_r || rdy_c;
  assign rdy_a     = !va_r || rdy_b;
  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      vw_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_tvalid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_w) vw_r <= div_out_valid;
      if (rdy_o) vo_r <= vw_r;
    end
  end

  // ---------------- stage a: capture, setup check ----------------
  logic [dtjc_pkg::RAW_W-1:0] raw_a_r;
  logic                       err_a_r, blank_a_r;
  logic                       setup_bad;

  assign setup_bad = (scale_r == '0) || ($signed(far_r) <= $signed(near_r));

  always_ff @(posedge clk) begin
    if (rdy_a && in_tvalid) begin
      raw_a_r   <= in_tdata;
      err_a_r   <= setup_bad;
      blank_a_r <= setup_bad || (in_tdata == '0);
    end
  end

  // ---------------- stage b: depth = raw * scale, range ----------------
  logic [DEPTHW-1:0] depth_b_r;
  logic [31:0]       range_b_r;   // far - near, positive when setup is good
  logic              err_b_r, blank_b_r;
  logic [32:0]       range_full;

  assign range_full = {far_r[31], far_r} - {near_r[31], near_r};

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      depth_b_r <= DEPTHW'(raw_a_r) * DEPTHW'(scale_r);
      range_b_r <= range_full[31:0];
      err_b_r   <= err_a_r;
      blank_b_r <= blank_a_r;
    end
  end

  // ---------------- stage c: diff = depth - near (Q.24) ----------------
  logic [DIFFW-1:0] diff_c_r;
  logic [31:0]      range_c_r;
  logic             err_c_r, blank_c_r;
  logic [DIFFW-1:0] near_q24;

  assign near_q24 = {{(DIFFW-40){near_r[31]}}, near_r, 8'h00};

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      diff_c_r  <= {2'b00, depth_b_r} - near_q24;
      range_c_r <= range_b_r;
      err_c_r   <= err_b_r;
      blank_c_r <= blank_b_r;
    end
  end

  // ---------------- stage d: clamp test, divider operands ----------------
  logic [31:0]      p0_d_r, range_d_r;
  logic [7:0]       low_d_r;
  dtjc_pkg::side_t  side_d_r;
  logic             le_zero, ge_range;

  assign le_zero  = diff_c_r[DIFFW-1] || (diff_c_r == '0);
  assign ge_range = !diff_c_r[DIFFW-1] &&
                    (diff_c_r >= {{(DIFFW-40){1'b0}}, range_c_r, 8'h00});

  always_ff @(posedge clk) begin
    if (rdy_d && vc_r) begin
      // t = 0 falls out of a zero dividend
      p0_d_r         <= (le_zero || ge_range) ? '0 : diff_c_r[39:8];
      low_d_r        <= (le_zero || ge_range) ? '0 : diff_c_r[7:0];
      range_d_r      <= range_c_r;
      side_d_r.err   <= err_c_r;
      side_d_r.blank <= blank_c_r;
      side_d_r.sat   <= !le_zero && ge_range;
    end
  end

  // ---------------- divider: t = diff * 2^N / (range * 2^8) ----------------
  logic [N-1:0]     q_div;
  dtjc_pkg::side_t  side_div;

  dtjc_div #(
    .NormFracBits (N)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vd_r),
    .in_ready  (div_in_ready),
    .in_p      (p0_d_r),
    .in_low    (low_d_r),
    .in_rng    (range_d_r),
    .in_side   (side_d_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_w),
    .out_q     (q_div),
    .out_side  (side_div)
  );

  // ---------------- stage w: triangle waves ----------------
  logic [N:0]                 t_val;
  logic signed [N+3:0]        t4;
  logic [2:0][N:0]            wv_nxt;
  logic [2:0][N:0]            wv_r;     // red, green, blue
  logic                       err_w_r, blank_w_r;

  assign t_val = side_div.sat ? One : {1'b0, q_div};
  assign t4    = $signed({1'b0, t_val, 2'b00});

  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_wave
      // red centers at 3, green at 2, blue at 1
      localparam logic signed [N+3:0] KOne = (N+4)'(3 - c) << N;
      logic signed [N+3:0] offs, mag, v;

      assign offs = t4 - KOne;
      assign mag  = offs[N+3] ? -offs : offs;
      assign v    = OneHlf - mag;

      always_comb begin
        if (v[N+3]) begin
          wv_nxt[c] = '0;
        end else if (v > $signed({3'b000, One})) begin
          wv_nxt[c] = One;
        end else begin
          wv_nxt[c] = v[N:0];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy_w && div_out_valid) begin
      wv_r      <= wv_nxt;
      err_w_r   <= side_div.err;
      blank_w_r <= side_div.blank;
    end
  end

  // ---------------- stage o: scale to 8 bits, output register ----------------
  logic [2:0][CHW-1:0] ch_nxt;
  logic [2:0][CHW-1:0] ch_r;
  logic                err_o_r;

  generate
    for (c = 0; c < 3; c++) begin : g_scale
      logic [N+8:0] prod;
      // v * 255 + 0.5, rounded half up
      assign prod      = {wv_r[c], 8'h00} - {8'h00, wv_r[c]} + Half;
      assign ch_nxt[c] = blank_w_r ? '0 : prod[N+7:N];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy_o && vw_r) begin
      ch_r    <= ch_nxt;
      err_o_r <= err_w_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {dtjc_pkg::ALPHA_VAL, ch_r[2], ch_r[1], ch_r[0]};
  assign out_tuser  = err_o_r;

endmodule
